// ----- hw/rtl/iwsp_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Inter-warp stride prefetcher package
// Shared sizes, types and the command and status structures that join the
// controller to the datapath.
// ----------------------------------------------------------------------------
package iwsp_pkg;

   localparam int TABLE_ENTRIES = 32;
   localparam int MAX_WARPS     = 64;
   localparam int IDX_W         = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int WARP_W        = 6;
   localparam int PC_W          = 32;
   localparam int ADDR_W        = 64;
   localparam int CNT_W         = $clog2(ADDR_W + 1);

   typedef logic [PC_W-1:0]   pc_type;
   typedef logic [WARP_W-1:0] warp_type;
   typedef logic [ADDR_W-1:0] addr_type;
   typedef logic [IDX_W-1:0]  idx_type;

   typedef struct packed {
      logic load;
      logic scan;
      logic div_start;
      logic div_step;
      logic mul;
      logic finish;
      logic write;
   } cmd_type;

   typedef struct packed {
      logic scan_last;
      logic hit;
      logic same;
      logic div_last;
   } stat_type;

endpackage

// ----- hw/rtl/iwsp_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Inter-warp stride prefetcher controller
// Sequences lookup, division, prefetch address and table update for an item.
// ----------------------------------------------------------------------------
module iwsp_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   input  iwsp_pkg::stat_type stat,
   output iwsp_pkg::cmd_type  cmd
);
   import iwsp_pkg::*;

   typedef enum logic [6:0] {
      S_IDLE  = 7'b0000001,
      S_SCAN  = 7'b0000010,
      S_DIVI  = 7'b0000100,
      S_DIV   = 7'b0001000,
      S_MUL   = 7'b0010000,
      S_FIN   = 7'b0100000,
      S_OUT   = 7'b1000000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            cmd.scan = 1'b1;
            if (stat.scan_last) begin
               if (stat.hit && !stat.same) state_in = S_DIVI;
               else state_in = S_FIN;
            end
         end
         S_DIVI: begin
            cmd.div_start = 1'b1;
            state_in = S_DIV;
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (stat.div_last) state_in = S_MUL;
         end
         S_MUL: begin
            cmd.mul = 1'b1;
            state_in = S_FIN;
         end
         S_FIN: begin
            cmd.finish = 1'b1;
            cmd.write = 1'b1;
            state_in = S_OUT;
         end
         S_OUT: begin
            if (rsp_ready) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = (state_ff == S_OUT);

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else state_ff <= state_in;
   end

endmodule

// ----- hw/rtl/iwsp_dp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Inter-warp stride prefetcher datapath
// Entry table, sequential lookup, restoring divider and result registers.
// ----------------------------------------------------------------------------
module iwsp_dp (
   input  logic                  clock,
   input  logic                  reset,
   input  iwsp_pkg::cmd_type     cmd,
   output iwsp_pkg::stat_type    stat,
   input  iwsp_pkg::pc_type      req_pc,
   input  iwsp_pkg::warp_type    req_warp_id,
   input  iwsp_pkg::addr_type    req_address,
   input  iwsp_pkg::warp_type    req_target_warp_id,
   output logic                  rsp_hit,
   output logic                  rsp_same_warp,
   output logic                  rsp_stride_equal,
   output logic signed [63:0]    rsp_computed_stride,
   output logic                  rsp_prefetch_valid,
   output iwsp_pkg::addr_type    rsp_prefetch_address
);
   import iwsp_pkg::*;

   logic [TABLE_ENTRIES-1:0] valid_ff;
   pc_type   tpc_mem   [TABLE_ENTRIES];
   warp_type twarp_mem [TABLE_ENTRIES];
   addr_type taddr_mem [TABLE_ENTRIES];
   addr_type tstr_mem  [TABLE_ENTRIES];
   idx_type  rp_ff;

   pc_type   pc_ff;
   warp_type warp_ff, tgt_ff, ewarp_ff;
   addr_type addr_ff, eaddr_ff, estr_ff;
   idx_type  scan_ff, hidx_ff;
   logic     hit_ff, same_ff, vld_ff, rdv_ff, rd_last_ff;
   pc_type   rpc_ff;
   idx_type  ridx_ff;
   warp_type rwarp_ff;
   addr_type raddr_ff, rstr_ff;

   addr_type rem_ff, quo_ff, num_ff;
   logic [WARP_W-1:0] den_ff;
   logic     qneg_ff;
   logic [CNT_W-1:0] cnt_ff;
   addr_type stride_ff, prod_ff;
   logic     match_ff;

   logic [WARP_W:0] wdiff;
   logic [WARP_W:0] tdiff;
   addr_type dnum, rem_sh, quo_fix;
   logic [ADDR_W:0] trial;

   // Read port: one entry per cycle, data registered.
   always_ff @(posedge clock) begin
      rpc_ff   <= tpc_mem[scan_ff];
      rwarp_ff <= twarp_mem[scan_ff];
      raddr_ff <= taddr_mem[scan_ff];
      rstr_ff  <= tstr_mem[scan_ff];
      vld_ff   <= valid_ff[scan_ff];
      ridx_ff  <= scan_ff;
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         pc_ff   <= req_pc;
         warp_ff <= req_warp_id;
         addr_ff <= req_address;
         tgt_ff  <= req_target_warp_id;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_ff    <= '0;
         rdv_ff     <= 1'b0;
         rd_last_ff <= 1'b0;
         hit_ff     <= 1'b0;
      end else if (cmd.load) begin
         scan_ff    <= '0;
         rdv_ff     <= 1'b0;
         rd_last_ff <= 1'b0;
         hit_ff     <= 1'b0;
      end else if (cmd.scan) begin
         rdv_ff     <= 1'b1;
         rd_last_ff <= (scan_ff == idx_type'(TABLE_ENTRIES - 1));
         if (scan_ff != idx_type'(TABLE_ENTRIES - 1)) scan_ff <= scan_ff + 1'b1;
         if (rdv_ff && !hit_ff && vld_ff && rpc_ff == pc_ff) begin
            hit_ff   <= 1'b1;
            hidx_ff  <= ridx_ff;
            ewarp_ff <= rwarp_ff;
            eaddr_ff <= raddr_ff;
            estr_ff  <= rstr_ff;
         end
      end
   end

   logic cur_hit;
   assign cur_hit = rdv_ff && vld_ff && rpc_ff == pc_ff;
   always_comb begin
      stat.scan_last = rdv_ff && rd_last_ff;
      stat.hit       = hit_ff || cur_hit;
      stat.same      = hit_ff ? (ewarp_ff == warp_ff) : (rwarp_ff == warp_ff);
      stat.div_last  = (cnt_ff == CNT_W'(1));
   end

   assign wdiff = {1'b0, ewarp_ff} - {1'b0, warp_ff};
   assign tdiff = {1'b0, tgt_ff} - {1'b0, warp_ff};
   assign dnum  = eaddr_ff - addr_ff;
   assign rem_sh = {rem_ff[ADDR_W-2:0], num_ff[ADDR_W-1]};
   assign trial  = {1'b0, rem_sh} - {{(ADDR_W-WARP_W+1){1'b0}}, den_ff};
   assign quo_fix = qneg_ff ? (addr_type'(0) - quo_ff) : quo_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else if (cmd.load) begin
         stride_ff <= '0;
         match_ff  <= 1'b0;
      end else if (cmd.div_start) begin
         num_ff  <= dnum[ADDR_W-1] ? (addr_type'(0) - dnum) : dnum;
         den_ff  <= wdiff[WARP_W] ? WARP_W'(~wdiff + 1'b1) : wdiff[WARP_W-1:0];
         qneg_ff <= dnum[ADDR_W-1] ^ wdiff[WARP_W];
         rem_ff  <= '0;
         quo_ff  <= '0;
         cnt_ff  <= CNT_W'(ADDR_W);
      end else if (cmd.div_step) begin
         num_ff <= {num_ff[ADDR_W-2:0], 1'b0};
         cnt_ff <= cnt_ff - 1'b1;
         if (!trial[ADDR_W]) begin
            rem_ff <= trial[ADDR_W-1:0];
            quo_ff <= {quo_ff[ADDR_W-2:0], 1'b1};
         end else begin
            rem_ff <= rem_sh;
            quo_ff <= {quo_ff[ADDR_W-2:0], 1'b0};
         end
      end else if (cmd.mul) begin
         stride_ff <= quo_fix;
         match_ff  <= (quo_fix == estr_ff);
         prod_ff   <= quo_fix * {{(ADDR_W-WARP_W-1){tdiff[WARP_W]}}, tdiff};
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.scan && !hit_ff && cur_hit) same_ff <= (rwarp_ff == warp_ff);
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         rsp_hit              <= hit_ff;
         rsp_same_warp        <= hit_ff && same_ff;
         rsp_stride_equal     <= hit_ff && !same_ff && match_ff;
         rsp_computed_stride  <= (hit_ff && !same_ff) ? stride_ff : '0;
         rsp_prefetch_valid   <= hit_ff && !same_ff && match_ff;
         rsp_prefetch_address <= (hit_ff && !same_ff && match_ff) ?
                                 addr_ff + prod_ff : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.write) begin
         if (hit_ff) begin
            twarp_mem[hidx_ff] <= warp_ff;
            taddr_mem[hidx_ff] <= addr_ff;
            if (!same_ff) tstr_mem[hidx_ff] <= stride_ff;
         end else begin
            tpc_mem[rp_ff]   <= pc_ff;
            twarp_mem[rp_ff] <= warp_ff;
            taddr_mem[rp_ff] <= addr_ff;
            tstr_mem[rp_ff]  <= '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         rp_ff    <= '0;
      end else if (cmd.write && !hit_ff) begin
         valid_ff[rp_ff] <= 1'b1;
         rp_ff <= (rp_ff == idx_type'(TABLE_ENTRIES - 1)) ? '0 : rp_ff + 1'b1;
      end
   end

endmodule

// ----- hw/rtl/inter_warp_stride_prefetcher.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Inter-warp stride prefetcher
// PC-indexed table that predicts a stride between warps and issues prefetches.
// ----------------------------------------------------------------------------
// A miss or same-warp hit scans the whole table; a cross-warp hit also runs
// the bit-serial 64-bit divider.
// Throughput: one item at a time; a new item is taken only after the response
// for the last one has been accepted.
// Reset clears all valid bits and the replacement pointer at once.
module inter_warp_stride_prefetcher (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  iwsp_pkg::pc_type    req_pc,
   input  iwsp_pkg::warp_type  req_warp_id,
   input  iwsp_pkg::addr_type  req_address,
   input  iwsp_pkg::warp_type  req_target_warp_id,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic                rsp_hit,
   output logic                rsp_same_warp,
   output logic                rsp_stride_equal,
   output logic signed [63:0]  rsp_computed_stride,
   output logic                rsp_prefetch_valid,
   output iwsp_pkg::addr_type  rsp_prefetch_address
);
   import iwsp_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   iwsp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   iwsp_dp u_dp (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .stat                 (stat),
      .req_pc               (req_pc),
      .req_warp_id          (req_warp_id),
      .req_address          (req_address),
      .req_target_warp_id   (req_target_warp_id),
      .rsp_hit              (rsp_hit),
      .rsp_same_warp        (rsp_same_warp),
      .rsp_stride_equal     (rsp_stride_equal),
      .rsp_computed_stride  (rsp_computed_stride),
      .rsp_prefetch_valid   (rsp_prefetch_valid),
      .rsp_prefetch_address (rsp_prefetch_address)
   );

`ifndef SYNTHESIS
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("Input accepted while an item is still held.");
   a_pf_match: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_prefetch_valid == rsp_stride_equal))
      else $error("Prefetch issued without a stride match.");
   a_same_hit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_same_warp |-> rsp_hit && !rsp_prefetch_valid)
      else $error("Same-warp flag without a plain hit.");
`endif

endmodule
